>>> hdl/crcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crcs_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W = 32;  // Q16.16 sample and position
  localparam int unsigned FRAC_W   = 16;  // Q0.16 fraction
  localparam int unsigned TAP_W    = 18;  // signed neighbor index before clamping
  localparam int unsigned WSUM_W   = 54;  // twice-weight at scale 2^48, with headroom
  localparam int unsigned PROD_W   = 64;  // sample times Q2.30 weight
  localparam int unsigned RND_W    = 34;  // rounded sum before limiting
  localparam int unsigned NUM_TAPS = 4;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Four neighbor samples plus the limit interval, one sample word
  typedef struct packed {
    logic    valid;
    sample_t s0;
    sample_t s1;
    sample_t s2;
    sample_t s3;
    sample_t lo;
    sample_t hi;
  } taps_t;

  // Catmull-Rom weights in Q2.30
  typedef struct packed {
    sample_t wa;
    sample_t wb;
    sample_t wc;
    sample_t wd;
  } weights_t;

endpackage

`default_nettype wire

>>> hdl/crcs_fetch.sv
`timescale 1ns / 1ps
`default_nettype none

module crcs_fetch #(
  parameter int GRID_CELLS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [7:0]           wr_index_i,
  input  crcs_pkg::sample_t    wr_value_i,
  input  logic                 valid_i,
  input  logic signed [15:0]   base_i,
  output crcs_pkg::taps_t      taps_o
);

  localparam int IDX_W      = $clog2(GRID_CELLS);
  localparam int BANK_AW    = (IDX_W > 3) ? IDX_W - 2 : 1;
  localparam int BANK_DEPTH = (GRID_CELLS + 3) / 4;
  localparam int NUM_BANKS  = 4;

  logic signed [crcs_pkg::TAP_W-1:0] tap_raw  [crcs_pkg::NUM_TAPS];
  logic [IDX_W-1:0]                  tap_idx  [crcs_pkg::NUM_TAPS];
  logic [IDX_W+1:0]                  tap_ext  [crcs_pkg::NUM_TAPS];
  logic [1:0]                        tap_bank [crcs_pkg::NUM_TAPS];
  logic [BANK_AW-1:0]                tap_addr [crcs_pkg::NUM_TAPS];
  logic [BANK_AW-1:0]                rd_addr  [NUM_BANKS];

  logic [31:0]        wr_ext;
  logic               wr_ok;
  logic [1:0]         wr_bank;
  logic [BANK_AW-1:0] wr_addr;

  crcs_pkg::sample_t rd_q   [NUM_BANKS];
  logic [1:0]        sel_q  [crcs_pkg::NUM_TAPS];
  crcs_pkg::sample_t tap3_q [crcs_pkg::NUM_TAPS];
  logic              v2_q;
  logic              v3_q;
  crcs_pkg::taps_t   taps_d;
  crcs_pkg::taps_t   taps_q;

  // Clamp the four neighbor indices and route each to its bank (index mod 4).
  // Clamped indices are consecutive or repeated, so no two distinct ones share a bank.
  always_comb begin
    for (int t = 0; t < crcs_pkg::NUM_TAPS; t++) begin
      tap_raw[t] = crcs_pkg::TAP_W'(base_i) + $signed(crcs_pkg::TAP_W'(t))
                   - $signed(crcs_pkg::TAP_W'(1));
      if (tap_raw[t] < $signed(crcs_pkg::TAP_W'(0))) begin
        tap_idx[t] = '0;
      end else if (tap_raw[t] > $signed(crcs_pkg::TAP_W'(GRID_CELLS - 1))) begin
        tap_idx[t] = IDX_W'(GRID_CELLS - 1);
      end else begin
        tap_idx[t] = tap_raw[t][IDX_W-1:0];
      end
      tap_ext[t]  = {2'b00, tap_idx[t]};
      tap_bank[t] = tap_idx[t][1:0];
      tap_addr[t] = tap_ext[t][BANK_AW+1:2];
    end
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_addr[b] = '0;
      for (int t = 0; t < crcs_pkg::NUM_TAPS; t++) begin
        if (tap_bank[t] == 2'(b)) begin
          rd_addr[b] = tap_addr[t];
        end
      end
    end
  end

  // Split the write index into bank and row; drop writes beyond the store
  assign wr_ext  = 32'(wr_index_i);
  assign wr_ok   = wr_en_i && (wr_ext < 32'(GRID_CELLS));
  assign wr_bank = wr_ext[1:0];
  assign wr_addr = wr_ext[BANK_AW+1:2];

  // Four banks, one write port and one registered read port each
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    crcs_pkg::sample_t mem_q [BANK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_ok && (wr_bank == 2'(b))) begin
        mem_q[wr_addr] <= wr_value_i;
      end
      rd_q[b] <= mem_q[rd_addr[b]];
    end
  end

  // Carry bank selects, then pick each tap from its bank
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < crcs_pkg::NUM_TAPS; t++) begin
      sel_q[t]  <= tap_bank[t];
      tap3_q[t] <= rd_q[sel_q[t]];
    end
  end

  // Form the limit interval from the two middle taps
  always_comb begin
    taps_d.valid = v3_q;
    taps_d.s0    = tap3_q[0];
    taps_d.s1    = tap3_q[1];
    taps_d.s2    = tap3_q[2];
    taps_d.s3    = tap3_q[3];
    if (tap3_q[1] < tap3_q[2]) begin
      taps_d.lo = tap3_q[1];
      taps_d.hi = tap3_q[2];
    end else begin
      taps_d.lo = tap3_q[2];
      taps_d.hi = tap3_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      taps_q <= '0;
    end else begin
      v2_q   <= valid_i;
      v3_q   <= v2_q;
      taps_q <= taps_d;
    end
  end

  assign taps_o = taps_q;

endmodule

`default_nettype wire

>>> hdl/crcs_weights.sv
`timescale 1ns / 1ps
`default_nettype none

module crcs_weights (
  input  logic                               clk_i,
  input  logic [crcs_pkg::FRAC_W-1:0]        frac_i,
  output crcs_pkg::weights_t                 weights_o
);

  localparam int unsigned W = crcs_pkg::WSUM_W;
  localparam logic signed [W-1:0] TWO_Q48 = W'(1) << 49;
  localparam logic signed [W-1:0] HALF_LSB = W'(1) << 18;

  logic [crcs_pkg::FRAC_W-1:0]   f2_q;
  logic [2*crcs_pkg::FRAC_W-1:0] sq2_q;
  logic [crcs_pkg::FRAC_W-1:0]   f3_q;
  logic [2*crcs_pkg::FRAC_W-1:0] sq3_q;
  logic [3*crcs_pkg::FRAC_W-1:0] cube3_q;

  logic signed [W-1:0] cube;
  logic signed [W-1:0] sq;
  logic signed [W-1:0] lin;
  logic signed [W-1:0] sa;
  logic signed [W-1:0] sb;
  logic signed [W-1:0] sc;
  logic signed [W-1:0] sd;

  crcs_pkg::weights_t weights_d;
  crcs_pkg::weights_t weights_q;

  // Square, then cube, one multiply per stage
  always_ff @(posedge clk_i) begin
    f2_q    <= frac_i;
    sq2_q   <= (2*crcs_pkg::FRAC_W)'(frac_i) * (2*crcs_pkg::FRAC_W)'(frac_i);
    f3_q    <= f2_q;
    sq3_q   <= sq2_q;
    cube3_q <= (3*crcs_pkg::FRAC_W)'(sq2_q) * (3*crcs_pkg::FRAC_W)'(f2_q);
  end

  // Twice each weight at scale 2^48, plus half an output LSB
  always_comb begin
    cube = $signed({6'b0, cube3_q});
    sq   = $signed({6'b0, sq3_q, 16'b0});
    lin  = $signed({6'b0, f3_q, 32'b0});
    sa   = (sq <<< 1) - cube - lin + HALF_LSB;
    sb   = (cube <<< 1) + cube - (sq <<< 2) - sq + TWO_Q48 + HALF_LSB;
    sc   = (sq <<< 2) + lin - (cube <<< 1) - cube + HALF_LSB;
    sd   = cube - sq + HALF_LSB;
    // Drop 19 bits: Q2.30 weights, rounded to nearest
    weights_d.wa = sa[50:19];
    weights_d.wb = sb[50:19];
    weights_d.wc = sc[50:19];
    weights_d.wd = sd[50:19];
  end

  always_ff @(posedge clk_i) begin
    weights_q <= weights_d;
  end

  assign weights_o = weights_q;

endmodule

`default_nettype wire

>>> hdl/crcs_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module crcs_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crcs_pkg::taps_t     taps_i,
  input  crcs_pkg::weights_t  weights_i,
  output logic                valid_o,
  output crcs_pkg::sample_t   sample_o
);

  localparam int unsigned PW = crcs_pkg::PROD_W;
  localparam int unsigned RW = crcs_pkg::RND_W;
  localparam logic signed [PW-1:0] HALF_OUT = PW'(1) << 29;

  logic signed [PW-1:0] prod_d [crcs_pkg::NUM_TAPS];
  logic signed [PW-1:0] prod_q [crcs_pkg::NUM_TAPS];
  logic signed [PW-1:0] pair_q [2];
  logic signed [PW-1:0] total;
  logic signed [RW-1:0] rnd_q;
  logic signed [RW-1:0] lo_ext;
  logic signed [RW-1:0] hi_ext;
  crcs_pkg::sample_t    lo5_q, hi5_q, lo6_q, hi6_q, lo7_q, hi7_q;
  crcs_pkg::sample_t    out_d;
  crcs_pkg::sample_t    out_q;
  logic                 v5_q, v6_q, v7_q, v8_q;

  // Multiply each tap by its weight
  always_comb begin
    prod_d[0] = PW'(taps_i.s0) * PW'(weights_i.wa);
    prod_d[1] = PW'(taps_i.s1) * PW'(weights_i.wb);
    prod_d[2] = PW'(taps_i.s2) * PW'(weights_i.wc);
    prod_d[3] = PW'(taps_i.s3) * PW'(weights_i.wd);
  end

  // Round the exact sum to Q16.16
  assign total = pair_q[0] + pair_q[1] + HALF_OUT;

  // Limit to the interval of the two middle samples
  always_comb begin
    lo_ext = RW'(lo7_q);
    hi_ext = RW'(hi7_q);
    if (rnd_q > hi_ext) begin
      out_d = hi7_q;
    end else if (rnd_q < lo_ext) begin
      out_d = lo7_q;
    end else begin
      out_d = rnd_q[crcs_pkg::SAMPLE_W-1:0];
    end
  end

  // Datapath stages: products, pair sums, rounding, limit
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < crcs_pkg::NUM_TAPS; k++) begin
      prod_q[k] <= prod_d[k];
    end
    lo5_q     <= taps_i.lo;
    hi5_q     <= taps_i.hi;
    pair_q[0] <= prod_q[0] + prod_q[1];
    pair_q[1] <= prod_q[2] + prod_q[3];
    lo6_q     <= lo5_q;
    hi6_q     <= hi5_q;
    rnd_q     <= total[PW-1:30];
    lo7_q     <= lo6_q;
    hi7_q     <= hi6_q;
    out_q     <= out_d;
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v5_q <= taps_i.valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  assign valid_o  = v8_q;
  assign sample_o = out_q;

endmodule

`default_nettype wire

>>> hdl/catmull_rom_clamped_sampler.sv
// Clamped Catmull-Rom sampler over a store of GRID_CELLS signed Q16.16
// samples. Raise start with a command word; busy never rises, so a word is
// taken on every clock. A write word (cmd_i = 0) stores entry_value_i at
// entry_index_i and returns nothing; indexes at or beyond GRID_CELLS are
// dropped. A sample word (cmd_i = 1) returns one result on sample_out_o,
// marked by sample_valid_o for a single cycle, in order; the receiver
// cannot stall it, so capture it then. One word per clock is sustained.
// A sample word passes through the register stages: position capture,
// banked store read, tap select and limit interval (in parallel with
// square, cube and weights), the four 32x32 products, pair sums, rounding,
// and the final limit. The store is banked four ways by index mod 4 so the
// four neighbors are read in the same cycle.
// Entries hold nothing defined until written: sample only over written
// entries. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_clamped_sampler #(
  parameter int GRID_CELLS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd_i,
  input  logic [7:0]            entry_index_i,
  input  logic signed [31:0]    entry_value_i,
  input  logic signed [31:0]    position_i,
  output logic                  sample_valid_o,
  output logic signed [31:0]    sample_out_o
);

  localparam int LATENCY = 8;

  logic                accept;
  logic                wr_en;
  logic                v1_q;
  crcs_pkg::sample_t   pos_q;
  crcs_pkg::taps_t     taps;
  crcs_pkg::weights_t  weights;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wr_en  = accept && (cmd_i == crcs_pkg::CMD_WRITE);

  // Capture the sample position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept && (cmd_i == crcs_pkg::CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= position_i;
  end

  crcs_fetch #(
    .GRID_CELLS (GRID_CELLS)
  ) u_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_index_i (entry_index_i),
    .wr_value_i (entry_value_i),
    .valid_i    (v1_q),
    .base_i     (pos_q[31:16]),
    .taps_o     (taps)
  );

  crcs_weights u_weights (
    .clk_i     (clk_i),
    .frac_i    (pos_q[crcs_pkg::FRAC_W-1:0]),
    .weights_o (weights)
  );

  crcs_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .taps_i    (taps),
    .weights_i (weights),
    .valid_o   (sample_valid_o),
    .sample_o  (sample_out_o)
  );

  // Every sample word taken yields a valid result
  a_sample_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == crcs_pkg::CMD_SAMPLE)) |-> ##LATENCY sample_valid_o)
    else $error("sample word produced no result");

  // No result without a sample word taken at the matching edge
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> $past(start && !busy && (cmd_i == crcs_pkg::CMD_SAMPLE), LATENCY))
    else $error("result without a matching sample word");

endmodule

`default_nettype wire
